// ----- src/dqec_pkg.sv -----
package dqec_pkg;

    localparam int COUNT_W   = 16;
    localparam int TOTAL_W   = 32;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 8;
    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 2 * COUNT_W + 2 * TOTAL_W;

    localparam logic [CFG_IDX_W-1:0] REG_REVERSE_FIRST  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE_SECOND = CFG_IDX_W'(1);

    localparam logic REVERSE_FIRST_RESET  = 1'b0;
    localparam logic REVERSE_SECOND_RESET = 1'b1;

    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic opcode;
        logic encoder_select;
        logic edge_on_second_pin;
        logic level_first_pin;
        logic level_second_pin;
    } event_t;

endpackage

// ----- src/dual_quadrature_edge_counter_unit.sv -----
// channel | direction | handshake          | payload
// s_      | in        | s_tvalid/s_tready  | s_tdata, s_tuser
// m_      | out       | m_tvalid/m_tready  | m_tdata
// cfg_    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// one item per cycle sustained while m_tready is high; an s_ transfer reaches m_tvalid
// through the input register, then the count update into the result register
// aresetn is synchronous: clears counters, totals, valid flags, and reverse bits
// to their defaults
// while m_tready is low the result register holds and one more item is taken
// into the input register, then s_tready drops
// cfg_ready is always high
module dual_quadrature_edge_counter_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [0] edge_on_second_pin, [1] level_first_pin, [2] level_second_pin, rest zero
    input  logic [dqec_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] opcode, [1] encoder_select
    input  logic [dqec_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [15:0] period_count_zero, [31:16] period_count_one,
    // [63:32] total_zero, [95:64] total_one
    output logic [dqec_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dqec_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dqec_pkg::CFG_DAT_W-1:0] cfg_data
);

    localparam int CW = dqec_pkg::COUNT_W;
    localparam int TW = dqec_pkg::TOTAL_W;

    logic                  in_valid_reg;
    dqec_pkg::event_t      in_event_reg;
    logic                  out_valid_reg;
    logic [dqec_pkg::M_TDATA_W-1:0] out_data_reg;

    logic                  reverse_first_reg;
    logic                  reverse_second_reg;
    logic signed [CW-1:0]  live_zero_reg, live_zero_next;
    logic signed [CW-1:0]  live_one_reg, live_one_next;
    logic signed [CW-1:0]  latched_zero_reg, latched_zero_next;
    logic signed [CW-1:0]  latched_one_reg, latched_one_next;
    logic signed [TW-1:0]  sum_zero_reg, sum_zero_next;
    logic signed [TW-1:0]  sum_one_reg, sum_one_next;

    logic                  advance;
    logic                  load;
    logic                  odd;
    logic                  rev;
    logic                  down;
    logic signed [CW-1:0]  delta;

    assign advance   = !out_valid_reg || m_tready;
    assign load      = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    always_comb begin
        odd   = !in_event_reg.edge_on_second_pin ^ in_event_reg.level_first_pin
              ^ in_event_reg.level_second_pin;
        rev   = in_event_reg.encoder_select ? reverse_second_reg : reverse_first_reg;
        down  = odd ^ rev;
        delta = down ? -CW'(1) : CW'(1);

        live_zero_next    = live_zero_reg;
        live_one_next     = live_one_reg;
        latched_zero_next = latched_zero_reg;
        latched_one_next  = latched_one_reg;
        sum_zero_next     = sum_zero_reg;
        sum_one_next      = sum_one_reg;

        if (in_event_reg.opcode == dqec_pkg::OP_TICK) begin
            sum_zero_next     = sum_zero_reg + TW'(latched_zero_reg);
            sum_one_next      = sum_one_reg + TW'(latched_one_reg);
            latched_zero_next = live_zero_reg;
            latched_one_next  = live_one_reg;
            live_zero_next    = '0;
            live_one_next     = '0;
        end else if (in_event_reg.encoder_select) begin
            live_one_next = live_one_reg + delta;
        end else begin
            live_zero_next = live_zero_reg + delta;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            reverse_first_reg  <= dqec_pkg::REVERSE_FIRST_RESET;
            reverse_second_reg <= dqec_pkg::REVERSE_SECOND_RESET;
            live_zero_reg      <= '0;
            live_one_reg       <= '0;
            latched_zero_reg   <= '0;
            latched_one_reg    <= '0;
            sum_zero_reg       <= '0;
            sum_one_reg        <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (load) begin
                live_zero_reg    <= live_zero_next;
                live_one_reg     <= live_one_next;
                latched_zero_reg <= latched_zero_next;
                latched_one_reg  <= latched_one_next;
                sum_zero_reg     <= sum_zero_next;
                sum_one_reg      <= sum_one_next;
            end
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    dqec_pkg::REG_REVERSE_FIRST:  reverse_first_reg  <= cfg_data[0];
                    dqec_pkg::REG_REVERSE_SECOND: reverse_second_reg <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_event_reg.opcode             <= s_tuser[0];
            in_event_reg.encoder_select     <= s_tuser[1];
            in_event_reg.edge_on_second_pin <= s_tdata[0];
            in_event_reg.level_first_pin    <= s_tdata[1];
            in_event_reg.level_second_pin   <= s_tdata[2];
        end
        if (load) begin
            out_data_reg <= {sum_one_next, sum_zero_next, latched_one_next, latched_zero_next};
        end
    end

`ifndef SYNTHESIS
    a_tick_clears_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && in_event_reg.opcode == dqec_pkg::OP_TICK)
        |=> (live_zero_reg == '0 && live_one_reg == '0))
        else $error("live counts not cleared after tick");

    a_edge_other_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && in_event_reg.opcode == dqec_pkg::OP_EDGE && !in_event_reg.encoder_select)
        |=> ($stable(live_one_reg) && $stable(sum_zero_reg) && $stable(latched_zero_reg)))
        else $error("edge on encoder zero disturbed other state");

    a_result_matches_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[CW-1:0] == latched_zero_reg
                   && m_tdata[2*CW-1:CW] == latched_one_reg
                   && m_tdata[2*CW+TW-1:2*CW] == sum_zero_reg
                   && m_tdata[2*CW+2*TW-1:2*CW+TW] == sum_one_reg))
        else $error("result register out of step with counter state");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a full pipeline");
`endif

endmodule

// ----- test/tb_dual_quadrature_edge_counter_unit.sv -----
`timescale 1ns / 1ps

module tb_dual_quadrature_edge_counter_unit;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 275;
    localparam int PHASES      = 6;
    localparam int LONG_HOLD   = 80;

    typedef struct {
        logic [dqec_pkg::COUNT_W-1:0] period_zero;
        logic [dqec_pkg::COUNT_W-1:0] period_one;
        logic [dqec_pkg::TOTAL_W-1:0] total_zero;
        logic [dqec_pkg::TOTAL_W-1:0] total_one;
    } counts_t;

    class count_tracker;
        logic                         rev_first;
        logic                         rev_second;
        logic [dqec_pkg::COUNT_W-1:0] live_zero;
        logic [dqec_pkg::COUNT_W-1:0] live_one;
        logic [dqec_pkg::COUNT_W-1:0] latch_zero;
        logic [dqec_pkg::COUNT_W-1:0] latch_one;
        logic [dqec_pkg::TOTAL_W-1:0] sum_zero;
        logic [dqec_pkg::TOTAL_W-1:0] sum_one;
        counts_t                      pending_counts[$];
        int                           mismatches;

        function new();
            rev_first  = dqec_pkg::REVERSE_FIRST_RESET;
            rev_second = dqec_pkg::REVERSE_SECOND_RESET;
            live_zero  = '0;
            live_one   = '0;
            latch_zero = '0;
            latch_one  = '0;
            sum_zero   = '0;
            sum_one    = '0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [dqec_pkg::CFG_IDX_W-1:0] idx,
                              logic [dqec_pkg::CFG_DAT_W-1:0] data);
            if (idx == dqec_pkg::REG_REVERSE_FIRST) begin
                rev_first = data[0];
            end else if (idx == dqec_pkg::REG_REVERSE_SECOND) begin
                rev_second = data[0];
            end
        endfunction

        function int pending();
            return pending_counts.size();
        endfunction

        function void note_event(dqec_pkg::event_t ev);
            logic    down;
            counts_t c;
            if (ev.opcode == dqec_pkg::OP_EDGE) begin
                // even parity of (first-pin flag, levels) counts up
                down = ~ev.edge_on_second_pin ^ ev.level_first_pin ^ ev.level_second_pin
                       ^ (ev.encoder_select ? rev_second : rev_first);
                if (ev.encoder_select) begin
                    live_one = down ? live_one - 1'b1 : live_one + 1'b1;
                end else begin
                    live_zero = down ? live_zero - 1'b1 : live_zero + 1'b1;
                end
            end else begin
                sum_zero   = sum_zero
                           + {{(dqec_pkg::TOTAL_W-dqec_pkg::COUNT_W)
                               {latch_zero[dqec_pkg::COUNT_W-1]}}, latch_zero};
                sum_one    = sum_one
                           + {{(dqec_pkg::TOTAL_W-dqec_pkg::COUNT_W)
                               {latch_one[dqec_pkg::COUNT_W-1]}}, latch_one};
                latch_zero = live_zero;
                latch_one  = live_one;
                live_zero  = '0;
                live_one   = '0;
            end
            c.period_zero = latch_zero;
            c.period_one  = latch_one;
            c.total_zero  = sum_zero;
            c.total_one   = sum_one;
            pending_counts.push_back(c);
        endfunction

        function void check_counts(logic [dqec_pkg::M_TDATA_W-1:0] data);
            counts_t want;
            counts_t got;
            got.period_zero = data[0 +: dqec_pkg::COUNT_W];
            got.period_one  = data[dqec_pkg::COUNT_W +: dqec_pkg::COUNT_W];
            got.total_zero  = data[2*dqec_pkg::COUNT_W +: dqec_pkg::TOTAL_W];
            got.total_one   = data[2*dqec_pkg::COUNT_W+dqec_pkg::TOTAL_W +: dqec_pkg::TOTAL_W];
            if (pending_counts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result transfer: %h", data);
                end
                return;
            end
            want = pending_counts.pop_front();
            if (got.period_zero !== want.period_zero || got.period_one !== want.period_one ||
                got.total_zero !== want.total_zero || got.total_one !== want.total_one) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("count mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                             $signed(want.period_zero), $signed(want.period_one),
                             $signed(want.total_zero), $signed(want.total_one),
                             $signed(got.period_zero), $signed(got.period_one),
                             $signed(got.total_zero), $signed(got.total_one));
                end
            end
        endfunction
    endclass

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [dqec_pkg::S_TDATA_W-1:0] s_tdata;
    logic [dqec_pkg::S_TUSER_W-1:0] s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [dqec_pkg::M_TDATA_W-1:0] m_tdata;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [dqec_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [dqec_pkg::CFG_DAT_W-1:0] cfg_data;

    count_tracker tracker = new();

    bit   calm;
    int   long_hold;
    logic quad_a[2];
    logic quad_b[2];
    logic quad_dir[2];

    dual_quadrature_edge_counter_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    task automatic send_item(dqec_pkg::event_t ev);
        s_tvalid <= 1'b1;
        s_tdata  <= dqec_pkg::S_TDATA_W'({ev.level_second_pin, ev.level_first_pin,
                                          ev.edge_on_second_pin});
        s_tuser  <= {ev.encoder_select, ev.opcode};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic write_cfg(logic [dqec_pkg::CFG_IDX_W-1:0] idx,
                             logic [dqec_pkg::CFG_DAT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain();
        @(posedge aclk);
        while (tracker.pending() != 0) @(posedge aclk);
    endtask

    function automatic logic [dqec_pkg::CFG_DAT_W-1:0] cfg_word(logic b);
        logic [dqec_pkg::CFG_DAT_W-1:0] w;
        w    = dqec_pkg::CFG_DAT_W'($urandom);
        w[0] = b;
        return w;
    endfunction

    // next edge of a real x4 sequence, direction reverses now and then
    function automatic dqec_pkg::event_t quad_event();
        dqec_pkg::event_t ev;
        logic             e;
        logic             pin;
        e = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 15) == 0) begin
            quad_dir[e] = ~quad_dir[e];
        end
        pin = (quad_a[e] != quad_b[e]) ^ quad_dir[e];
        if (pin) begin
            quad_b[e] = ~quad_b[e];
        end else begin
            quad_a[e] = ~quad_a[e];
        end
        ev.opcode             = dqec_pkg::OP_EDGE;
        ev.encoder_select     = e;
        ev.edge_on_second_pin = pin;
        ev.level_first_pin    = quad_a[e];
        ev.level_second_pin   = quad_b[e];
        return ev;
    endfunction

    always @(posedge aclk) begin : monitor
        dqec_pkg::event_t seen;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                tracker.set_reg(cfg_index, cfg_data);
            end
            if (s_tvalid && s_tready) begin
                seen.opcode             = s_tuser[0];
                seen.encoder_select     = s_tuser[1];
                seen.edge_on_second_pin = s_tdata[0];
                seen.level_first_pin    = s_tdata[1];
                seen.level_second_pin   = s_tdata[2];
                tracker.note_event(seen);
            end
            if (m_tvalid && m_tready) begin
                tracker.check_counts(m_tdata);
            end
        end
    end

    initial begin : receiver
        forever begin
            if (long_hold > 0) begin
                m_tready <= 1'b0;
                repeat (long_hold) @(posedge aclk);
                long_hold = 0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        dqec_pkg::event_t ev;
        int               ph;
        int               i;
        int unsigned      roll;
        logic             rf;
        logic             rs;

        calm      = 1'b0;
        long_hold = 0;
        quad_a    = '{default: 1'b0};
        quad_b    = '{default: 1'b0};
        quad_dir  = '{default: 1'b0};
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // every edge combination on both encoders under reset directions
        for (i = 0; i < 16; i++) begin
            ev        = dqec_pkg::event_t'({1'b0, i[3:0]});
            ev.opcode = dqec_pkg::OP_EDGE;
            send_item(ev);
        end
        // push encoder zero negative, then ticks with junk fields
        ev = '0;
        ev.opcode = dqec_pkg::OP_EDGE;
        repeat (3) send_item(ev);
        ev = dqec_pkg::event_t'(5'h1f);
        ev.opcode = dqec_pkg::OP_TICK;
        send_item(ev);
        ev = '0;
        ev.opcode = dqec_pkg::OP_TICK;
        send_item(ev);
        ev = dqec_pkg::event_t'(5'h15);
        ev.opcode = dqec_pkg::OP_TICK;
        send_item(ev);
        s_tvalid <= 1'b0;

        for (ph = 0; ph < PHASES; ph++) begin
            drain();
            case (ph)
                0: begin
                    rf = 1'b1;
                    rs = 1'b1;
                end
                1: begin
                    rf = 1'b0;
                    rs = 1'b0;
                end
                2: begin
                    rf = 1'b1;
                    rs = 1'b0;
                end
                4: begin
                    rf = dqec_pkg::REVERSE_FIRST_RESET;
                    rs = dqec_pkg::REVERSE_SECOND_RESET;
                end
                default: begin
                    rf = 1'($urandom);
                    rs = 1'($urandom);
                end
            endcase
            if (ph == PHASES - 1) begin
                calm = 1'b1;
            end
            write_cfg(dqec_pkg::CFG_IDX_W'($urandom_range(2, 255)),
                      dqec_pkg::CFG_DAT_W'($urandom));
            write_cfg(dqec_pkg::REG_REVERSE_FIRST, cfg_word(rf));
            write_cfg(dqec_pkg::REG_REVERSE_SECOND, cfg_word(rs));

            for (i = 0; i < PHASE_ITEMS; i++) begin
                if (ph == 1 && i == 100) begin
                    long_hold = LONG_HOLD;
                end
                if (ph == 2 && i == 150) begin
                    s_tvalid <= 1'b0;
                    drain();
                end
                if (!calm && $urandom_range(0, 3) == 0) begin
                    s_tvalid <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge aclk);
                end
                roll = $urandom_range(0, 19);
                if (roll < 2) begin
                    ev        = dqec_pkg::event_t'(5'($urandom));
                    ev.opcode = dqec_pkg::OP_TICK;
                end else if (roll < 5) begin
                    ev = dqec_pkg::event_t'(5'($urandom));
                end else begin
                    ev = quad_event();
                end
                send_item(ev);
            end
            s_tvalid <= 1'b0;
        end

        drain();
        repeat (8) @(posedge aclk);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
